// ===== rtl/core/lpp_pkg.sv =====
// shared types and constants for the lidar point to pixel projection
// no dependencies
`default_nettype none
package lpp_pkg;

  localparam int COEF_W     = 32;
  localparam int POINT_W    = 32;
  localparam int PIX_W      = 12;
  localparam int DEPTH_W    = 8;
  localparam int DIM_CFG_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd240;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_XY  = 3'd0,
    CFG_ROW0_ZT  = 3'd1,
    CFG_ROW1_XY  = 3'd2,
    CFG_ROW1_ZT  = 3'd3,
    CFG_ROW2_XY  = 3'd4,
    CFG_ROW2_ZT  = 3'd5,
    CFG_WIDTH    = 3'd6,
    CFG_HEIGHT   = 3'd7
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpp_if.sv =====
// channel interfaces for points, pixels and register writes
// depends on lpp_pkg
`default_nettype none
interface lpp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lpp_pkg::POINT_W-1:0]  point_x;
  logic signed [lpp_pkg::POINT_W-1:0]  point_y;
  logic signed [lpp_pkg::POINT_W-1:0]  point_z;
  logic                                point_bad;
  modport source(output valid, point_x, point_y, point_z, point_bad, input ready);
  modport sink(input valid, point_x, point_y, point_z, point_bad, output ready);
endinterface

interface lpp_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpp_pkg::PIX_W-1:0]     pixel_col;
  logic [lpp_pkg::PIX_W-1:0]     pixel_row;
  logic [lpp_pkg::DEPTH_W-1:0]   depth_colour;
  modport source(output valid, pixel_col, pixel_row, depth_colour, input ready);
  modport sink(input valid, pixel_col, pixel_row, depth_colour, output ready);
endinterface

interface lpp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpp_pkg::CFG_IDX_W-1:0]    index;
  logic [lpp_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpp_row.sv =====
// one projection row: three registered products, then the registered row sum
// depends on lpp_pkg
`default_nettype none
module lpp_row #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int SUM_W           = 50
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic signed [lpp_pkg::POINT_W-1:0]      point_x,
  input  wire logic signed [lpp_pkg::POINT_W-1:0]      point_y,
  input  wire logic signed [lpp_pkg::POINT_W-1:0]      point_z,
  input  wire logic [2*lpp_pkg::COEF_W-1:0]            coef_xy,
  input  wire logic [2*lpp_pkg::COEF_W-1:0]            coef_zt,
  output logic signed [SUM_W-1:0]                      row_sum
);

  localparam int PROD_W = lpp_pkg::COEF_W + lpp_pkg::POINT_W;

  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= $signed(coef_xy[lpp_pkg::COEF_W-1:0]) * point_x;
      prod_y_r <= $signed(coef_xy[2*lpp_pkg::COEF_W-1:lpp_pkg::COEF_W]) * point_y;
      prod_z_r <= $signed(coef_zt[lpp_pkg::COEF_W-1:0]) * point_z;
      sum_r    <= SUM_W'(prod_x_r >>> COORD_FRAC_BITS)
                + SUM_W'(prod_y_r >>> COORD_FRAC_BITS)
                + SUM_W'(prod_z_r >>> COORD_FRAC_BITS)
                + SUM_W'($signed(coef_zt[2*lpp_pkg::COEF_W-1:lpp_pkg::COEF_W]));
    end
  end

  assign row_sum = sum_r;

endmodule
`default_nettype wire

// ===== rtl/core/lpp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// no dependencies beyond the package convention
`default_nettype none
module lpp_div #(
  parameter int DIVD_W = 50,
  parameter int QUO_W  = 12
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVD_W-1:0] divisor,
  output logic [QUO_W-1:0]       quotient
);

  localparam int EXT_W = DIVD_W + QUO_W;

  logic [DIVD_W-1:0] rem_r [QUO_W];
  logic [DIVD_W-1:0] dsr_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DIVD_W-1:0] rem_in;
    logic [DIVD_W-1:0] dsr_in;
    logic [QUO_W-1:0]  quo_in;
    logic [EXT_W-1:0]  trial;
    logic [EXT_W-1:0]  diff;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign dsr_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dsr_in = dsr_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = EXT_W'(dsr_in) << (QUO_W - 1 - k);
    assign take  = EXT_W'(rem_in) >= trial;
    assign diff  = EXT_W'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DIVD_W-1:0] : rem_in;
        dsr_r[k] <= dsr_in;
        quo_r[k] <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
      end
    end
  end

  assign quotient = quo_r[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/lidar_point_to_pixel_projection.sv =====
// lidar point to pixel projection, top level
// stages: input, products, row sums, range checks, dividers, output; one point per cycle
// sustained unless the pixel side stalls; pipelined multipliers, one-bit-per-stage dividers
// a stall on the pixel side holds every stage
// rst_n clears the valid bits and loads the register defaults (zero matrix, 240 x 180 image)
// depends on lpp_pkg, lpp_if, lpp_row, lpp_div
`default_nettype none
module lidar_point_to_pixel_projection #(
  parameter int MAX_DIM_BITS    = 12,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpp_in_if.sink      in_chan,
  lpp_out_if.source   out_chan,
  lpp_cfg_if.sink     cfg_chan
);

  localparam int SUM_W = 66 - COORD_FRAC_BITS;
  localparam int EXT_W = SUM_W + MAX_DIM_BITS + 1;
  localparam int CMP_W = (MAX_DIM_BITS > lpp_pkg::DIM_CFG_W) ?
                         MAX_DIM_BITS + 1 : lpp_pkg::DIM_CFG_W + 1;
  localparam int MD    = MAX_DIM_BITS;

  // configuration
  logic [lpp_pkg::CFG_DATA_W-1:0] row_xy_r [3];
  logic [lpp_pkg::CFG_DATA_W-1:0] row_zt_r [3];
  logic [lpp_pkg::DIM_CFG_W-1:0]  width_r, height_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        row_xy_r[i] <= '0;
        row_zt_r[i] <= '0;
      end
      width_r  <= lpp_pkg::WIDTH_RST;
      height_r <= lpp_pkg::HEIGHT_RST;
    end else if (cfg_chan.valid) begin
      case (lpp_pkg::cfg_reg_t'(cfg_chan.index))
        lpp_pkg::CFG_ROW0_XY: row_xy_r[0] <= cfg_chan.data;
        lpp_pkg::CFG_ROW0_ZT: row_zt_r[0] <= cfg_chan.data;
        lpp_pkg::CFG_ROW1_XY: row_xy_r[1] <= cfg_chan.data;
        lpp_pkg::CFG_ROW1_ZT: row_zt_r[1] <= cfg_chan.data;
        lpp_pkg::CFG_ROW2_XY: row_xy_r[2] <= cfg_chan.data;
        lpp_pkg::CFG_ROW2_ZT: row_zt_r[2] <= cfg_chan.data;
        lpp_pkg::CFG_WIDTH:   width_r  <= cfg_chan.data[lpp_pkg::DIM_CFG_W-1:0];
        lpp_pkg::CFG_HEIGHT:  height_r <= cfg_chan.data[lpp_pkg::DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  logic out_valid_r;
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 0: input register and drop filter
  logic signed [lpp_pkg::POINT_W-1:0] x0_r, y0_r, z0_r;
  logic v0_r, v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_chan.point_x;
      y0_r <= in_chan.point_y;
      z0_r <= in_chan.point_z;
    end
  end

  // stages 1 and 2: products and row sums
  logic signed [SUM_W-1:0] sum_a, sum_b, sum_c;

  lpp_row #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SUM_W(SUM_W)) u_row0 (
    .clk(clk), .en(en), .point_x(x0_r), .point_y(y0_r), .point_z(z0_r),
    .coef_xy(row_xy_r[0]), .coef_zt(row_zt_r[0]), .row_sum(sum_a)
  );
  lpp_row #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SUM_W(SUM_W)) u_row1 (
    .clk(clk), .en(en), .point_x(x0_r), .point_y(y0_r), .point_z(z0_r),
    .coef_xy(row_xy_r[1]), .coef_zt(row_zt_r[1]), .row_sum(sum_b)
  );
  lpp_row #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SUM_W(SUM_W)) u_row2 (
    .clk(clk), .en(en), .point_x(x0_r), .point_y(y0_r), .point_z(z0_r),
    .coef_xy(row_xy_r[2]), .coef_zt(row_zt_r[2]), .row_sum(sum_c)
  );

  // stage 3: depth sign and quotient range checks
  logic signed [EXT_W-1:0] a_ext, b_ext, c_ext, c_lim;
  logic c_pos, a_ok, b_ok;

  assign a_ext = EXT_W'(sum_a);
  assign b_ext = EXT_W'(sum_b);
  assign c_ext = EXT_W'(sum_c);
  assign c_lim = c_ext <<< MD;
  assign c_pos = !sum_c[SUM_W-1] && (sum_c != '0);
  assign a_ok  = sum_a[SUM_W-1] ? ((-a_ext) < c_ext) : (a_ext < c_lim);
  assign b_ok  = sum_b[SUM_W-1] ? ((-b_ext) < c_ext) : (b_ext < c_lim);

  logic [SUM_W-1:0]               divd_a_r, divd_b_r, divs_r;
  logic [lpp_pkg::DEPTH_W-1:0]    dep3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      divd_a_r <= sum_a[SUM_W-1] ? '0 : sum_a;
      divd_b_r <= sum_b[SUM_W-1] ? '0 : sum_b;
      divs_r   <= sum_c;
      dep3_r   <= sum_c[COORD_FRAC_BITS +: lpp_pkg::DEPTH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid && !in_chan.point_bad && !in_chan.point_x[lpp_pkg::POINT_W-1];
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r && c_pos && a_ok && b_ok;
    end
  end

  // division stages
  logic [MD-1:0] quo_a, quo_b;

  lpp_div #(.DIVD_W(SUM_W), .QUO_W(MD)) u_div_col (
    .clk(clk), .en(en), .dividend(divd_a_r), .divisor(divs_r), .quotient(quo_a)
  );
  lpp_div #(.DIVD_W(SUM_W), .QUO_W(MD)) u_div_row (
    .clk(clk), .en(en), .dividend(divd_b_r), .divisor(divs_r), .quotient(quo_b)
  );

  logic                        vd_r  [MD];
  logic [lpp_pkg::DEPTH_W-1:0] dep_r [MD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MD; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v3_r;
      for (int i = 1; i < MD; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dep_r[0] <= dep3_r;
      for (int i = 1; i < MD; i++) dep_r[i] <= dep_r[i-1];
    end
  end

  // output register: image bounds check
  logic pass;
  assign pass = vd_r[MD-1]
             && (CMP_W'(quo_a) < CMP_W'(width_r))
             && (CMP_W'(quo_b) < CMP_W'(height_r));

  logic [lpp_pkg::PIX_W-1:0]   col_r, row_r;
  logic [lpp_pkg::DEPTH_W-1:0] depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pass;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r   <= lpp_pkg::PIX_W'(quo_a);
      row_r   <= lpp_pkg::PIX_W'(quo_b);
      depth_r <= dep_r[MD-1];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_col    = col_r;
  assign out_chan.pixel_row    = row_r;
  assign out_chan.depth_colour = depth_r;

endmodule
`default_nettype wire
